/* hdl/rtt_pkg.sv */
// Shared types, codes and constants of the request tag tracker.
// Used by the register block, the engine, the top level and the checker.
// No dependencies.
package rtt_pkg;

   // Default number of tracking slots.
   localparam int RTT_SLOTS = 8;

   // Id that no live request carries.
   localparam logic [15:0] INVALID_REQUEST_ID = 16'hFFFF;

   // Slot state codes; codes from ST_ERR_MIN upward are error states.
   localparam logic [3:0] ST_FREE    = 4'd0;
   localparam logic [3:0] ST_PENDING = 4'd1;
   localparam logic [3:0] ST_READY   = 4'd2;
   localparam logic [3:0] ST_TIMEOUT = 4'd3;
   localparam logic [3:0] ST_ERR_MIN = 4'd4;

   // Register block constants.
   localparam int          CSR_AW               = 2;
   localparam logic [1:0]  CSR_ADDR_TIMEOUT     = 2'd0;
   localparam logic [31:0] TIMEOUT_TICKS_RESET  = 32'd1000;

   // Input commands.
   typedef enum logic [2:0] {
      CMD_ALLOC    = 3'd0,
      CMD_CANCEL   = 3'd1,
      CMD_RESPONSE = 3'd2,
      CMD_TICK     = 3'd3,
      CMD_RELEASE  = 3'd4,
      CMD_CLEAR    = 3'd5
   } cmd_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_ALLOC    = 3'd0,
      KIND_CANCEL   = 3'd1,
      KIND_RESPONSE = 3'd2,
      KIND_TIMEOUT  = 3'd3,
      KIND_ACK      = 3'd4
   } kind_type;

   // One accepted input item, as held by the engine.
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] request_id;
      logic [31:0] now;
      logic        is_error;
      logic [3:0]  error_code;
      logic [2:0]  slot_sel;
   } item_type;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic        status;
      logic [2:0]  slot_index;
      logic [15:0] assigned_id;
      logic [3:0]  slot_state_out;
      logic        last;
   } rsp_type;

   // One slot as stored in the slot memory.
   typedef struct packed {
      logic [3:0]  state;
      logic [15:0] id;
      logic [31:0] stamp;
   } entry_type;

   // Builds a result item.
   function automatic rsp_type make_rsp(kind_type kind, logic status, logic [2:0] slot,
                                        logic [15:0] id, logic [3:0] st, logic last);
      rsp_type r;
      r.kind           = kind;
      r.status         = status;
      r.slot_index     = slot;
      r.assigned_id    = id;
      r.slot_state_out = st;
      r.last           = last;
      return r;
   endfunction

endpackage

/* hdl/rtt_req_if.sv */
// Input channel of the request tag tracker: valid/ready handshake and item fields.
// No dependencies.
interface rtt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] request_id;
   logic [31:0] now;
   logic        is_error;
   logic [3:0]  error_code;
   logic [2:0]  slot_sel;

   modport source (output valid, output cmd, output request_id, output now,
                   output is_error, output error_code, output slot_sel, input ready);
   modport sink   (input valid, input cmd, input request_id, input now,
                   input is_error, input error_code, input slot_sel, output ready);
endinterface

/* hdl/rtt_rsp_if.sv */
// Result channel of the request tag tracker: valid/ready handshake and result fields.
// No dependencies.
interface rtt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic        status;
   logic [2:0]  slot_index;
   logic [15:0] assigned_id;
   logic [3:0]  slot_state_out;
   logic        last;

   modport source (output valid, output kind, output status, output slot_index,
                   output assigned_id, output slot_state_out, output last, input ready);
   modport sink   (input valid, input kind, input status, input slot_index,
                   input assigned_id, input slot_state_out, input last, output ready);
endinterface

/* hdl/rtt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds while no read is enabled. No dependencies.
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/rtt_csr.sv */
// Register block of the request tag tracker: the timeout register on an APB-style port.
// Depends on rtt_pkg.
module rtt_csr import rtt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output logic [31:0]       timeout_ticks
);

   logic [31:0] timeout_ff;
   logic [31:0] timeout_in;

   // Write in the access phase of an addressed transfer.
   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && (paddr == CSR_ADDR_TIMEOUT)) begin
         timeout_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_TICKS_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // Read decode; unmapped addresses read as zero.
   always_comb begin
      unique case (paddr)
         CSR_ADDR_TIMEOUT: prdata = timeout_ff;
         default:          prdata = '0;
      endcase
   end

   assign pready        = 1'b1;
   assign timeout_ticks = timeout_ff;

endmodule

/* hdl/rtt_engine.sv */
// Command engine of the request tag tracker: slot memory, per-slot valid bits,
// the scan sequencer and the result register. Depends on rtt_pkg, rtt_ram and
// the channel interfaces.
module rtt_engine import rtt_pkg::*; #(
   parameter int SLOTS = RTT_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      timeout_ticks,
   rtt_req_if.sink          req,
   rtt_rsp_if.source        rsp
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(SLOTS + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_EXEC
   } state_type;

   state_type         state_ff,      state_in;
   item_type          item_ff,       item_in;
   logic [SLOTS-1:0]  valid_ff,      valid_in;
   logic [15:0]       next_id_ff,    next_id_in;
   logic [PW-1:0]     rd_ptr_ff,     rd_ptr_in;
   logic              ev_valid_ff,   ev_valid_in;
   logic [AW-1:0]     ev_idx_ff,     ev_idx_in;
   logic              held_valid_ff, held_valid_in;
   logic [AW-1:0]     held_idx_ff,   held_idx_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   rsp_type           rsp_data_ff,   rsp_data_in;

   logic              mem_we;
   entry_type         mem_wdata;
   logic              mem_re;
   logic [EW-1:0]     mem_rdata;
   entry_type         rd_entry;

   logic              ev_live;
   logic [3:0]        ev_state;
   logic [15:0]       ev_id;
   logic [31:0]       age;
   logic              hit;
   logic              is_last;
   logic              need_out;
   logic              out_free;
   logic [15:0]       alloc_id;
   logic [3:0]        resp_state;
   logic [AW-1:0]     sel_idx;

   // Slot memory: state, id and allocation stamp of every slot.
   rtt_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (ev_idx_ff),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (rd_ptr_ff[AW-1:0]),
      .rdata (mem_rdata)
   );

   assign rd_entry = entry_type'(mem_rdata);

   // A slot whose valid bit is clear reads as free with the invalid id.
   always_comb begin
      ev_live  = valid_ff[ev_idx_ff];
      ev_state = ev_live ? rd_entry.state : ST_FREE;
      ev_id    = ev_live ? rd_entry.id : INVALID_REQUEST_ID;
      age      = item_ff.now - rd_entry.stamp;
      is_last  = (ev_idx_ff == AW'(SLOTS - 1));
      alloc_id = (next_id_ff == INVALID_REQUEST_ID) ? 16'd0 : next_id_ff;
      if (!item_ff.is_error) begin
         resp_state = ST_READY;
      end else if (item_ff.error_code < ST_ERR_MIN) begin
         resp_state = ST_ERR_MIN;
      end else begin
         resp_state = item_ff.error_code;
      end
      sel_idx = AW'(item_ff.slot_sel);
   end

   // Match test of the slot under evaluation, per command.
   always_comb begin
      unique case (item_ff.cmd)
         CMD_ALLOC:    hit = (ev_state == ST_FREE);
         CMD_CANCEL:   hit = (ev_id == item_ff.request_id);
         CMD_RESPONSE: hit = (ev_id == item_ff.request_id) && (ev_state == ST_PENDING);
         CMD_TICK:     hit = (ev_state == ST_PENDING) && (age > timeout_ticks);
         default:      hit = 1'b0;
      endcase
   end

   // A scan step that produces a result waits for room in the result register.
   always_comb begin
      need_out = 1'b0;
      if (ev_valid_ff) begin
         if (item_ff.cmd == CMD_TICK) begin
            need_out = hit && held_valid_ff;
         end else begin
            need_out = hit || is_last;
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   // Sequencer: next state, memory accesses and result loading.
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      valid_in      = valid_ff;
      next_id_in    = next_id_ff;
      rd_ptr_in     = rd_ptr_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      held_valid_in = held_valid_ff;
      held_idx_in   = held_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wdata     = '{state: ST_PENDING, id: alloc_id, stamp: item_ff.now};
      mem_re        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               item_in.cmd        = cmd_type'(req.cmd);
               item_in.request_id = req.request_id;
               item_in.now        = req.now;
               item_in.is_error   = req.is_error;
               item_in.error_code = req.error_code;
               item_in.slot_sel   = req.slot_sel;
               rd_ptr_in          = '0;
               ev_valid_in        = 1'b0;
               held_valid_in      = 1'b0;
               unique case (cmd_type'(req.cmd))
                  CMD_ALLOC, CMD_CANCEL, CMD_RESPONSE, CMD_TICK: state_in = S_SCAN;
                  CMD_RELEASE, CMD_CLEAR:                        state_in = S_EXEC;
                  default:                                       state_in = S_IDLE;
               endcase
            end
         end

         S_SCAN: begin
            if (!need_out || out_free) begin
               // Read the next slot while the previous one is evaluated.
               mem_re      = (rd_ptr_ff < PW'(SLOTS));
               ev_valid_in = mem_re;
               if (mem_re) begin
                  rd_ptr_in = rd_ptr_ff + PW'(1);
                  ev_idx_in = rd_ptr_ff[AW-1:0];
               end
               if (ev_valid_ff) begin
                  unique case (item_ff.cmd)
                     CMD_ALLOC: begin
                        if (hit) begin
                           mem_we              = 1'b1;
                           valid_in[ev_idx_ff] = 1'b1;
                           next_id_in          = alloc_id + 16'd1;
                           rsp_valid_in        = 1'b1;
                           rsp_data_in = make_rsp(KIND_ALLOC, 1'b0, 3'(ev_idx_ff), alloc_id,
                                                  ST_PENDING, 1'b1);
                           state_in    = S_IDLE;
                        end else if (is_last) begin
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = make_rsp(KIND_ALLOC, 1'b1, 3'd0, INVALID_REQUEST_ID,
                                                   ST_FREE, 1'b1);
                           state_in     = S_IDLE;
                        end
                     end
                     CMD_CANCEL: begin
                        if (hit) begin
                           valid_in[ev_idx_ff] = 1'b0;
                           rsp_valid_in        = 1'b1;
                           rsp_data_in = make_rsp(KIND_CANCEL, 1'b0, 3'(ev_idx_ff),
                                                  INVALID_REQUEST_ID, ST_FREE, 1'b1);
                           state_in    = S_IDLE;
                        end else if (is_last) begin
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = make_rsp(KIND_CANCEL, 1'b1, 3'd0,
                                                   INVALID_REQUEST_ID, ST_FREE, 1'b1);
                           state_in     = S_IDLE;
                        end
                     end
                     CMD_RESPONSE: begin
                        if (hit) begin
                           mem_we       = 1'b1;
                           mem_wdata    = '{state: resp_state, id: INVALID_REQUEST_ID,
                                            stamp: item_ff.now};
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = make_rsp(KIND_RESPONSE, 1'b0, 3'(ev_idx_ff),
                                                   INVALID_REQUEST_ID, resp_state, 1'b1);
                           state_in     = S_IDLE;
                        end else if (is_last) begin
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = make_rsp(KIND_RESPONSE, 1'b1, 3'd0,
                                                   INVALID_REQUEST_ID, ST_FREE, 1'b1);
                           state_in     = S_IDLE;
                        end
                     end
                     CMD_TICK: begin
                        // Each expired slot is held back one step so that the
                        // final notice can carry the last flag.
                        if (hit) begin
                           valid_in[ev_idx_ff] = 1'b0;
                           if (held_valid_ff) begin
                              rsp_valid_in = 1'b1;
                              rsp_data_in  = make_rsp(KIND_TIMEOUT, 1'b0, 3'(held_idx_ff),
                                                      INVALID_REQUEST_ID, ST_TIMEOUT, 1'b0);
                           end
                           held_valid_in = 1'b1;
                           held_idx_in   = ev_idx_ff;
                        end
                        if (is_last) begin
                           state_in = S_FLUSH;
                        end
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end

         S_FLUSH: begin
            // Send the held notice, if any, as the final result of the tick.
            if (!held_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = make_rsp(KIND_TIMEOUT, 1'b0, 3'(held_idx_ff),
                                        INVALID_REQUEST_ID, ST_TIMEOUT, 1'b1);
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               unique case (item_ff.cmd)
                  CMD_RELEASE: begin
                     rsp_valid_in = 1'b1;
                     if (32'(item_ff.slot_sel) < 32'(SLOTS)) begin
                        valid_in[sel_idx] = 1'b0;
                        rsp_data_in = make_rsp(KIND_ACK, 1'b0, item_ff.slot_sel,
                                               INVALID_REQUEST_ID, ST_FREE, 1'b1);
                     end else begin
                        rsp_data_in = make_rsp(KIND_ACK, 1'b1, item_ff.slot_sel,
                                               INVALID_REQUEST_ID, ST_FREE, 1'b1);
                     end
                  end
                  CMD_CLEAR: begin
                     valid_in     = '0;
                     next_id_in   = INVALID_REQUEST_ID;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = make_rsp(KIND_ACK, 1'b0, 3'd0, INVALID_REQUEST_ID,
                                             ST_FREE, 1'b1);
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         next_id_ff    <= INVALID_REQUEST_ID;
         ev_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rd_ptr_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         next_id_ff    <= next_id_in;
         ev_valid_ff   <= ev_valid_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_ptr_ff     <= rd_ptr_in;
      end
      item_ff     <= item_in;
      ev_idx_ff   <= ev_idx_in;
      held_idx_ff <= held_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Result channel.
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_data_ff.kind;
   assign rsp.status         = rsp_data_ff.status;
   assign rsp.slot_index     = rsp_data_ff.slot_index;
   assign rsp.assigned_id    = rsp_data_ff.assigned_id;
   assign rsp.slot_state_out = rsp_data_ff.slot_state_out;
   assign rsp.last           = rsp_data_ff.last;

endmodule

/* hdl/request_tag_tracker_top.sv */
// Request tag tracker: tracks outstanding requests in a table of slots.
// The req_ch channel takes one command item (allocate, cancel, response, tick,
// release, clear); the rsp_ch channel returns its result items, the final one
// marked by last. Both use valid/ready; an item moves when both are high.
// The timeout register sits on the APB-style port (address 0).
// Allocate, cancel and response scan the slot memory one slot per cycle until
// the first match, or to the last slot when nothing matches; the scan pauses
// while a result waits on the result register. A tick reads every slot, and
// each notice may wait on the result register. Release and clear need no scan.
// The pace is set by the single read port of the slot memory.
// Reset empties every slot at once through per-slot valid bits, restores the
// timeout to 1000 and restarts the id counter; no clearing pass is needed.
// When the receiver stalls, the result register holds its item and the scan
// pauses at the next slot that produces a result. A new item is taken as soon
// as the previous one has loaded its final result, even while it still waits.
// Depends on rtt_pkg, rtt_req_if, rtt_rsp_if, rtt_csr and rtt_engine.
module request_tag_tracker_top import rtt_pkg::*; #(
   parameter int SLOTS = RTT_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   rtt_req_if.sink           req_ch,
   rtt_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [31:0] timeout_ticks;

   // Configuration registers.
   rtt_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .timeout_ticks (timeout_ticks)
   );

   // Slot table and command sequencer.
   rtt_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .timeout_ticks (timeout_ticks),
      .req           (req_ch),
      .rsp           (rsp_ch)
   );

endmodule

/* hdl/rtt_checker.sv */
// Port-level checks on the result channel of the request tag tracker, and the
// bind that attaches them to request_tag_tracker_top. Depends on rtt_pkg.
module rtt_checker import rtt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic        rsp_status,
   input logic [2:0]  rsp_slot_index,
   input logic [15:0] rsp_assigned_id,
   input logic [3:0]  rsp_slot_state_out,
   input logic        rsp_last
);

   // Reset drops any pending result.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_status)
         && $stable(rsp_slot_index) && $stable(rsp_assigned_id)
         && $stable(rsp_slot_state_out) && $stable(rsp_last))
      else $error("stalled result changed");

   // A granted allocation carries a real id and a pending slot.
   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ALLOC) && !rsp_status |->
         (rsp_assigned_id != INVALID_REQUEST_ID) && (rsp_slot_state_out == ST_PENDING))
      else $error("allocation reply inconsistent");

   // A failed operation names no slot state and no id.
   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         (rsp_slot_state_out == ST_FREE) && (rsp_assigned_id == INVALID_REQUEST_ID))
      else $error("failure reply inconsistent");

   // Timeout notices always succeed and report the timeout state.
   a_notice_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_TIMEOUT) |->
         !rsp_status && (rsp_slot_state_out == ST_TIMEOUT)
         && (rsp_assigned_id == INVALID_REQUEST_ID))
      else $error("timeout notice inconsistent");

endmodule

bind request_tag_tracker_top rtt_checker u_rtt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_kind           (rsp_ch.kind),
   .rsp_status         (rsp_ch.status),
   .rsp_slot_index     (rsp_ch.slot_index),
   .rsp_assigned_id    (rsp_ch.assigned_id),
   .rsp_slot_state_out (rsp_ch.slot_state_out),
   .rsp_last           (rsp_ch.last)
);
